### hw/rtl/first_fit_heap_allocator_defines.svh
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_defines
// Assertion macros used by the allocator top level.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FFHA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FFHA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

  localparam int SIZE_W    = 12;
  localparam int OFF_W     = 12;
  localparam int HDR_W     = 16;
  localparam int SUM_W     = 17;
  localparam int HDR_BYTES = 2;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_SPLIT,
    ST_MERGE,
    ST_NRD,
    ST_NEV,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_FIT,
    WR_SPLIT,
    WR_MERGE
  } wr_sel_t;

  typedef struct packed {
    logic    in_ready;
    logic    capture;
    logic    rd_next;
    logic    latch_cur;
    logic    advance;
    logic    latch_free;
    wr_sel_t wr;
    logic    merge_next;
    logic    finish;
    logic    fin_ok;
    logic    fin_where;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic is_free;
    logic req_zero;
    logic fit;
    logic split;
    logic has_next;
    logic pos_gt_off;
    logic pos_eq_off;
    logic v_neg;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/ffha_req_if.sv
// ----------------------------------------------------------------------------
// ffha_req_if
// Request channel: operation, size and block offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ffha_req_if;
  import ffha_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [SIZE_W-1:0] request_size;
  logic [OFF_W-1:0]  block_offset;

  modport source (output valid, output op, output request_size, output block_offset,
                  input ready);
  modport sink   (input valid, input op, input request_size, input block_offset,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/ffha_rsp_if.sv
// ----------------------------------------------------------------------------
// ffha_rsp_if
// Response channel: status and header offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ffha_rsp_if;
  import ffha_pkg::*;

  logic             valid;
  logic             ready;
  logic             ok;
  logic [OFF_W-1:0] result_offset;

  modport source (output valid, output ok, output result_offset, input ready);
  modport sink   (input valid, input ok, input result_offset, output ready);
endinterface

`default_nettype wire

### hw/rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Controller: walks the header chain and sequences header updates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffha_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  ffha_pkg::dp_status_t status,
  output ffha_pkg::dp_cmd_t    cmd,
  output ffha_pkg::state_t     state
);
  import ffha_pkg::*;

  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: state_next = ST_IDLE;
      ST_IDLE: begin
        if (status.in_valid) state_next = ST_RD;
      end
      ST_RD: begin
        if (!status.is_free && status.req_zero) state_next = ST_DONE;
        else state_next = ST_EV;
      end
      ST_EV: begin
        if (!status.is_free) begin
          priority if (status.fit) state_next = status.split ? ST_SPLIT : ST_DONE;
          else if (status.has_next) state_next = ST_RD;
          else state_next = ST_DONE;
        end else begin
          priority if (status.pos_gt_off) state_next = ST_DONE;
          else if (status.pos_eq_off) begin
            if (status.v_neg) state_next = ST_DONE;
            else state_next = status.has_next ? ST_NRD : ST_MERGE;
          end
          else if (status.has_next) state_next = ST_RD;
          else state_next = ST_DONE;
        end
      end
      ST_SPLIT: state_next = ST_DONE;
      ST_MERGE: state_next = ST_DONE;
      ST_NRD:   state_next = ST_NEV;
      ST_NEV:   state_next = ST_DONE;
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_INIT: cmd.wr = WR_INIT;
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.capture  = status.in_valid;
      end
      ST_RD: begin
        if (!status.is_free && status.req_zero) cmd.finish = 1'b1;
      end
      ST_EV: begin
        cmd.latch_cur = 1'b1;
        if (!status.is_free) begin
          priority if (status.fit) begin
            cmd.wr = WR_FIT;
            if (!status.split) begin
              cmd.finish    = 1'b1;
              cmd.fin_ok    = 1'b1;
              cmd.fin_where = 1'b1;
            end
          end
          else if (status.has_next) cmd.advance = 1'b1;
          else cmd.finish = 1'b1;
        end else begin
          priority if (status.pos_gt_off) cmd.finish = 1'b1;
          else if (status.pos_eq_off) begin
            if (status.v_neg) cmd.finish = 1'b1;
            else cmd.latch_free = 1'b1;
          end
          else if (status.has_next) cmd.advance = 1'b1;
          else cmd.finish = 1'b1;
        end
      end
      ST_SPLIT: begin
        cmd.wr        = WR_SPLIT;
        cmd.finish    = 1'b1;
        cmd.fin_ok    = 1'b1;
        cmd.fin_where = 1'b1;
      end
      ST_MERGE: begin
        cmd.wr     = WR_MERGE;
        cmd.finish = 1'b1;
        cmd.fin_ok = 1'b1;
      end
      ST_NRD: cmd.rd_next = 1'b1;
      ST_NEV: begin
        cmd.wr         = WR_MERGE;
        cmd.merge_next = 1'b1;
        cmd.finish     = 1'b1;
        cmd.fin_ok     = 1'b1;
      end
      ST_DONE: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/ffha_dp.sv
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath: header memory, chain pointers, size arithmetic, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffha_dp #(
  parameter int ARENA_SIZE = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ffha_pkg::dp_cmd_t    cmd,
  output ffha_pkg::dp_status_t status,
  ffha_req_if.sink             request,
  ffha_rsp_if.source           response
);
  import ffha_pkg::*;

  localparam int AW = $clog2(ARENA_SIZE);
  localparam logic [HDR_W-1:0] INIT_HDR  = HDR_W'(0 - (ARENA_SIZE - HDR_BYTES));
  localparam logic [SUM_W-1:0] ARENA_END = SUM_W'(ARENA_SIZE);
  localparam logic [SUM_W-1:0] HDR_LEN   = SUM_W'(HDR_BYTES);

  op_t               op;
  logic [SIZE_W-1:0] req_size;
  logic [OFF_W-1:0]  off;
  logic [AW-1:0]     pos;
  logic [AW-1:0]     prev_pos;
  logic [AW-1:0]     nxt_pos;
  logic [AW-1:0]     new_pos;
  logic              prev_free;
  logic [HDR_W-1:0]  prev_body;
  logic [HDR_W-1:0]  cur_body;
  logic [HDR_W-1:0]  new_sz;
  logic              fin_ok;
  logic [OFF_W-1:0]  fin_off;
  logic              out_valid;
  logic              out_ok;
  logic [OFF_W-1:0]  out_off;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [HDR_W-1:0]  wdata;
  logic [HDR_W-1:0]  rdata;

  logic              v_neg;
  logic [HDR_W-1:0]  body;
  logic [SUM_W-1:0]  next_sum;
  logic [SUM_W-1:0]  req_ext;
  logic [SUM_W-1:0]  merge_sum;
  logic              has_next;
  logic              split;

  ffha_ram #(
    .WIDTH (HDR_W),
    .DEPTH (ARENA_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign v_neg    = rdata[HDR_W-1];
  assign body     = v_neg ? (HDR_W'(0) - rdata) : rdata;
  assign next_sum = SUM_W'(pos) + HDR_LEN + SUM_W'(body);
  assign has_next = (next_sum + HDR_LEN) <= ARENA_END;
  assign req_ext  = SUM_W'(req_size);
  assign split    = SUM_W'(body) > (req_ext + HDR_LEN);
  assign merge_sum = SUM_W'(new_sz)
                   + ((cmd.merge_next && v_neg) ? (SUM_W'(body) + HDR_LEN) : SUM_W'(0));
  assign raddr    = cmd.rd_next ? nxt_pos : pos;

  always_comb begin
    we    = 1'b1;
    waddr = pos;
    wdata = rdata;
    unique case (cmd.wr)
      WR_NONE: we = 1'b0;
      WR_INIT: begin
        waddr = '0;
        wdata = INIT_HDR;
      end
      WR_FIT: begin
        waddr = pos;
        wdata = split ? HDR_W'(req_size) : body;
      end
      WR_SPLIT: begin
        waddr = AW'(SUM_W'(pos) + HDR_LEN + req_ext);
        wdata = HDR_W'(0) - HDR_W'(SUM_W'(cur_body) - HDR_LEN - req_ext);
      end
      WR_MERGE: begin
        waddr = new_pos;
        wdata = HDR_W'(0) - HDR_W'(merge_sum);
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    status.in_valid   = request.valid;
    status.is_free    = (op == OP_FREE);
    status.req_zero   = (req_size == '0);
    status.fit        = v_neg && (SUM_W'(body) >= req_ext);
    status.split      = split;
    status.has_next   = has_next;
    status.pos_gt_off = SUM_W'(pos) > SUM_W'(off);
    status.pos_eq_off = SUM_W'(pos) == SUM_W'(off);
    status.v_neg      = v_neg;
    status.out_free   = !out_valid || response.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      prev_free <= 1'b0;
    end else if (cmd.capture) begin
      pos       <= '0;
      prev_free <= 1'b0;
    end else if (cmd.advance) begin
      pos       <= AW'(next_sum);
      prev_free <= v_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op       <= op_t'(request.op);
      req_size <= request.request_size;
      off      <= request.block_offset;
    end
    if (cmd.advance) begin
      prev_pos  <= pos;
      prev_body <= body;
    end
    if (cmd.latch_cur) begin
      cur_body <= body;
      nxt_pos  <= AW'(next_sum);
    end
    if (cmd.latch_free) begin
      new_pos <= prev_free ? prev_pos : pos;
      new_sz  <= prev_free ? HDR_W'(SUM_W'(prev_body) + SUM_W'(body) + HDR_LEN) : body;
    end
    if (cmd.finish) begin
      fin_ok  <= cmd.fin_ok;
      fin_off <= cmd.fin_where ? OFF_W'(pos) : '0;
    end
    if (cmd.out_load) begin
      out_ok  <= fin_ok;
      out_off <= fin_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign request.ready          = cmd.in_ready;
  assign response.valid         = out_valid;
  assign response.ok            = out_ok;
  assign response.result_offset = out_off;

endmodule

`default_nettype wire

### hw/rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with coalescing over a header-chained byte arena.
// ----------------------------------------------------------------------------
// Usage:
//   request  (valid/ready): op 0 allocates request_size bytes, op 1 frees the
//            block whose header sits at block_offset.
//   response (valid/ready): ok and result_offset, one per request transaction.
//   One request is in flight at a time. Each block header visited takes a
//   read-address state, then an evaluate state on the registered read data,
//   through the single read port of the header memory. A split, or a merge
//   into the last block, adds a write state; a merge that reads the following
//   header adds a read state and a merge-evaluate state. An allocate of zero
//   bytes finishes in the read-address state, without evaluating a header.
//   A new request is taken the cycle after the result is loaded.
//   Reset writes the initial free header; request.ready stays low during reset
//   and in the init state after it. If the receiver stalls, the result holds
//   in the output register and the next finished result waits in the finish
//   registers and the controller waits in done until the register drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator #(
  parameter int ARENA_SIZE = 4096
) (
  input  logic       clk,
  input  logic       rst,
  ffha_req_if.sink   request,
  ffha_rsp_if.source response
);
  import ffha_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  state_t     state;

  ffha_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd),
    .state  (state)
  );

  ffha_dp #(
    .ARENA_SIZE (ARENA_SIZE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .request  (request),
    .response (response)
  );

  `FFHA_ASSERT_IMP(a_no_idle_write, clk, rst, cmd.wr != WR_NONE, (state != ST_IDLE && state != ST_DONE), "header write outside a walk")
  `FFHA_ASSERT_NXT(a_accept_walks, clk, rst, request.valid && request.ready, state == ST_RD, "accepted transaction did not start a walk")
  `FFHA_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.out_load, (!response.valid || response.ready), "result loaded over a pending transaction")

endmodule

`default_nettype wire
